FILE: rtl/psc_pkg.sv
package psc_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int ADC_BITS     = 12;

  localparam int COUNT_W  = 12;
  localparam int ALPHA_W  = 9;
  localparam int SPAN_W   = 17;
  localparam int PRESS_W  = 16;
  localparam int EMA_W    = 20;
  localparam int EMA_FRAC = 8;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;

  localparam int SUM_W  = COUNT_W + ((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int WP_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam int PROD_W    = COUNT_W + SPAN_W;
  localparam int DVD_W     = PROD_W + (PROD_W % 2);
  localparam int AVG_STEPS = (SUM_W + 1) / 2;
  localparam int SCL_STEPS = DVD_W / 2;
  localparam int AVG_SHIFT = DVD_W - 2 * AVG_STEPS;
  localparam int STEP_W    = $clog2(SCL_STEPS > AVG_STEPS ? SCL_STEPS : AVG_STEPS);

  localparam logic [COUNT_W-1:0] ADC_MASK  = COUNT_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;
  localparam logic [1:0] MODE_EMA    = 2'd2;

  localparam logic [2:0] REG_FILTER_MODE = 3'd0;
  localparam logic [2:0] REG_EMA_ALPHA   = 3'd1;
  localparam logic [2:0] REG_CLAMP_LOW   = 3'd2;
  localparam logic [2:0] REG_CLAMP_HIGH  = 3'd3;
  localparam logic [2:0] REG_SPAN        = 3'd4;
  localparam logic [2:0] REG_OFFSET      = 3'd5;
  localparam logic [2:0] REG_MAX         = 3'd6;

  localparam logic [ALPHA_W-1:0] RST_ALPHA  = ALPHA_W'(64);
  localparam logic [COUNT_W-1:0] RST_HIGH   = COUNT_W'(4095);
  localparam logic [SPAN_W-1:0]  RST_SPAN   = SPAN_W'(75000);
  localparam logic [PRESS_W-1:0] RST_OFFSET = PRESS_W'(12500);
  localparam logic [PRESS_W-1:0] RST_MAX    = PRESS_W'(50000);

endpackage

FILE: rtl/psc_ram.sv
module psc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pressure_sample_conditioner.sv
// Pressure sample conditioner: one ADC count per input beat gives one result beat with the
// pressure in tenths of PSI, the prefiltered count, the window average and a window-full
// flag. Items are processed one at a time: a new item is accepted only after the last
// one is loaded into the result register, and EMA mode adds a filter state. The shared
// restoring divider, which retires two quotient bits per cycle, computes the window
// average and then the span scaling. A finished result waits in the output register while
// the next item is accepted and processed. The window store is a 16-entry RAM with a
// registered read; a read entry is used only once the window is full, so the RAM needs no
// clearing after reset. Registers are to be written over the APB port only while no item
// is in flight; the block itself does not enforce this.
module pressure_sample_conditioner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [11:0]                    in_adc_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_pressure_tenths,
  output logic [11:0]                    out_filtered_count,
  output logic [11:0]                    out_average_count,
  output logic                           out_window_full,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]     paddr,
  input  logic [psc_pkg::DATA_W-1:0]     pwdata,
  output logic [psc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PRE  = 8'b0000_0010,
    S_EMA  = 8'b0000_0100,
    S_UPD  = 8'b0000_1000,
    S_AVG  = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_SCL  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } psc_state_t;

  localparam int CW = psc_pkg::COUNT_W;
  localparam int DW = psc_pkg::DVD_W;

  psc_state_t state_r, state_nxt;

  logic [1:0]                    filter_mode_r;
  logic [psc_pkg::ALPHA_W-1:0]   ema_alpha_r;
  logic [CW-1:0]                 clamp_low_r;
  logic [CW-1:0]                 clamp_high_r;
  logic [psc_pkg::SPAN_W-1:0]    span_r;
  logic [psc_pkg::PRESS_W-1:0]   offset_r;
  logic [psc_pkg::PRESS_W-1:0]   max_r;

  logic [psc_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [psc_pkg::WP_W-1:0]      wp_r, wp_nxt;
  logic [psc_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic [psc_pkg::EMA_W-1:0]     ema_r, ema_nxt;
  logic [CW-1:0]                 prev_one_r, prev_one_nxt;
  logic [CW-1:0]                 prev_two_r, prev_two_nxt;
  logic                          primed_r, primed_nxt;

  logic [CW-1:0]                 x_r, x_nxt;
  logic [CW-1:0]                 f_r, f_nxt;
  logic [CW-1:0]                 avg_r, avg_nxt;
  logic [20:0]                   ema_prod_r, ema_prod_nxt;
  logic [DW-1:0]                 dvd_r, dvd_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [CW-1:0]                 div_r, div_nxt;
  logic [psc_pkg::STEP_W-1:0]    step_r, step_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [15:0]                   out_press_r, out_press_nxt;
  logic [CW-1:0]                 out_filt_r, out_filt_nxt;
  logic [CW-1:0]                 out_avg_r, out_avg_nxt;
  logic                          out_full_r, out_full_nxt;

  logic                          in_accept;
  logic                          cfg_write;
  logic [2:0]                    cfg_idx;
  logic [CW-1:0]                 old_entry;
  logic                          win_full;
  logic                          ram_we;

  logic [psc_pkg::ALPHA_W-1:0]   alpha_c;
  logic [psc_pkg::ALPHA_W-1:0]   decay;
  logic [28:0]                   decay_prod;
  logic [21:0]                   ema_acc;
  logic [CW-1:0]                 med_a, med_b, med_m;

  logic [CW:0]                   trial1, trial2;
  logic                          ge1, ge2;
  logic [CW-1:0]                 rem1, rem2;
  logic [DW-1:0]                 dvd1, dvd2;

  logic [CW-1:0]                 cnt_lo, cnt_c;
  logic [psc_pkg::PROD_W-1:0]    scale_prod;
  logic [psc_pkg::SPAN_W-1:0]    scaled;
  logic [psc_pkg::SPAN_W-1:0]    press;
  logic                          out_load;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];
  assign pready    = 1'b1;
  assign win_full  = (fill_r == psc_pkg::FILL_W'(psc_pkg::WINDOW_DEPTH));
  assign ram_we    = (state_r == S_UPD);

  psc_ram #(
    .WIDTH (CW),
    .DEPTH (psc_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (f_r),
    .re    (in_accept),
    .raddr (wp_r),
    .rdata (old_entry)
  );

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      psc_pkg::REG_FILTER_MODE: prdata = psc_pkg::DATA_W'(filter_mode_r);
      psc_pkg::REG_EMA_ALPHA:   prdata = psc_pkg::DATA_W'(ema_alpha_r);
      psc_pkg::REG_CLAMP_LOW:   prdata = psc_pkg::DATA_W'(clamp_low_r);
      psc_pkg::REG_CLAMP_HIGH:  prdata = psc_pkg::DATA_W'(clamp_high_r);
      psc_pkg::REG_SPAN:        prdata = psc_pkg::DATA_W'(span_r);
      psc_pkg::REG_OFFSET:      prdata = psc_pkg::DATA_W'(offset_r);
      psc_pkg::REG_MAX:         prdata = psc_pkg::DATA_W'(max_r);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= psc_pkg::MODE_NONE;
      ema_alpha_r   <= psc_pkg::RST_ALPHA;
      clamp_low_r   <= '0;
      clamp_high_r  <= psc_pkg::RST_HIGH;
      span_r        <= psc_pkg::RST_SPAN;
      offset_r      <= psc_pkg::RST_OFFSET;
      max_r         <= psc_pkg::RST_MAX;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        psc_pkg::REG_FILTER_MODE: filter_mode_r <= pwdata[1:0];
        psc_pkg::REG_EMA_ALPHA:   ema_alpha_r   <= pwdata[psc_pkg::ALPHA_W-1:0];
        psc_pkg::REG_CLAMP_LOW:   clamp_low_r   <= pwdata[CW-1:0];
        psc_pkg::REG_CLAMP_HIGH:  clamp_high_r  <= pwdata[CW-1:0];
        psc_pkg::REG_SPAN:        span_r        <= pwdata[psc_pkg::SPAN_W-1:0];
        psc_pkg::REG_OFFSET:      offset_r      <= pwdata[psc_pkg::PRESS_W-1:0];
        psc_pkg::REG_MAX:         max_r         <= pwdata[psc_pkg::PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    alpha_c    = (ema_alpha_r > psc_pkg::ALPHA_ONE) ? psc_pkg::ALPHA_ONE : ema_alpha_r;
    decay      = psc_pkg::ALPHA_ONE - alpha_c;
    decay_prod = 29'(decay) * 29'(ema_r);
    ema_acc    = 22'(ema_prod_r) + 22'(decay_prod[28:psc_pkg::EMA_FRAC]);

    med_a = primed_r ? prev_one_r : x_r;
    med_b = primed_r ? prev_two_r : x_r;
    if ((x_r >= med_a && x_r <= med_b) || (x_r >= med_b && x_r <= med_a)) begin
      med_m = x_r;
    end else if ((med_a >= x_r && med_a <= med_b) || (med_a >= med_b && med_a <= x_r)) begin
      med_m = med_a;
    end else begin
      med_m = med_b;
    end

    trial1 = {rem_r, dvd_r[DW-1]};
    ge1    = (trial1 >= {1'b0, div_r});
    rem1   = ge1 ? CW'(trial1 - {1'b0, div_r}) : trial1[CW-1:0];
    dvd1   = {dvd_r[DW-2:0], ge1};
    trial2 = {rem1, dvd1[DW-1]};
    ge2    = (trial2 >= {1'b0, div_r});
    rem2   = ge2 ? CW'(trial2 - {1'b0, div_r}) : trial2[CW-1:0];
    dvd2   = {dvd1[DW-2:0], ge2};

    cnt_lo     = (dvd_r[CW-1:0] < clamp_low_r) ? clamp_low_r : dvd_r[CW-1:0];
    cnt_c      = (cnt_lo > clamp_high_r) ? clamp_high_r : cnt_lo;
    scale_prod = psc_pkg::PROD_W'(cnt_c) * psc_pkg::PROD_W'(span_r);

    scaled = dvd_r[psc_pkg::SPAN_W-1:0];
    press  = (scaled > psc_pkg::SPAN_W'(offset_r)) ?
             (scaled - psc_pkg::SPAN_W'(offset_r)) : '0;
    if (press > psc_pkg::SPAN_W'(max_r)) begin
      press = psc_pkg::SPAN_W'(max_r);
    end

    out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt    = state_r;
    sum_nxt      = sum_r;
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    ema_nxt      = ema_r;
    prev_one_nxt = prev_one_r;
    prev_two_nxt = prev_two_r;
    primed_nxt   = primed_r;
    x_nxt        = x_r;
    f_nxt        = f_r;
    avg_nxt      = avg_r;
    ema_prod_nxt = ema_prod_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    div_nxt      = div_r;
    step_nxt     = step_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_press_nxt = out_press_r;
    out_filt_nxt  = out_filt_r;
    out_avg_nxt   = out_avg_r;
    out_full_nxt  = out_full_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          x_nxt     = in_adc_sample & psc_pkg::ADC_MASK;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        case (filter_mode_r)
          psc_pkg::MODE_MEDIAN: begin
            f_nxt        = med_m;
            prev_two_nxt = med_a;
            prev_one_nxt = x_r;
            primed_nxt   = 1'b1;
            state_nxt    = S_UPD;
          end
          psc_pkg::MODE_EMA: begin
            ema_prod_nxt = 21'(alpha_c) * 21'(x_r);
            if (ema_r == '0) begin
              ema_nxt = {x_r, psc_pkg::EMA_FRAC'(0)};
            end
            state_nxt = S_EMA;
          end
          default: begin
            f_nxt     = x_r;
            state_nxt = S_UPD;
          end
        endcase
      end
      S_EMA: begin
        ema_nxt   = ema_acc[psc_pkg::EMA_W-1:0];
        f_nxt     = ema_acc[psc_pkg::EMA_W-1:psc_pkg::EMA_FRAC];
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (win_full) begin
          sum_nxt = sum_r - psc_pkg::SUM_W'(old_entry) + psc_pkg::SUM_W'(f_r);
        end else begin
          sum_nxt  = sum_r + psc_pkg::SUM_W'(f_r);
          fill_nxt = fill_r + 1'b1;
        end
        wp_nxt = (wp_r == psc_pkg::WP_W'(psc_pkg::WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        dvd_nxt   = DW'(sum_nxt) << psc_pkg::AVG_SHIFT;
        div_nxt   = CW'(fill_nxt);
        rem_nxt   = '0;
        step_nxt  = psc_pkg::STEP_W'(psc_pkg::AVG_STEPS - 1);
        state_nxt = S_AVG;
      end
      S_AVG: begin
        dvd_nxt  = dvd2;
        rem_nxt  = rem2;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        avg_nxt   = dvd_r[CW-1:0];
        dvd_nxt   = DW'(scale_prod);
        div_nxt   = (clamp_high_r == '0) ? CW'(1) : clamp_high_r;
        rem_nxt   = '0;
        step_nxt  = psc_pkg::STEP_W'(psc_pkg::SCL_STEPS - 1);
        state_nxt = S_SCL;
      end
      S_SCL: begin
        dvd_nxt  = dvd2;
        rem_nxt  = rem2;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_press_nxt = press[15:0];
          out_filt_nxt  = f_r;
          out_avg_nxt   = avg_r;
          out_full_nxt  = win_full;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      ema_r       <= '0;
      prev_one_r  <= '0;
      prev_two_r  <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      ema_r       <= ema_nxt;
      prev_one_r  <= prev_one_nxt;
      prev_two_r  <= prev_two_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    f_r         <= f_nxt;
    avg_r       <= avg_nxt;
    ema_prod_r  <= ema_prod_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    step_r      <= step_nxt;
    out_press_r <= out_press_nxt;
    out_filt_r  <= out_filt_nxt;
    out_avg_r   <= out_avg_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_pressure_tenths = out_press_r;
  assign out_filtered_count  = out_filt_r;
  assign out_average_count   = out_avg_r;
  assign out_window_full     = out_full_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 14;
  localparam int BEATS_PER_PHASE = 75;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [psc_pkg::PRESS_W-1:0] pressure;
    logic [psc_pkg::COUNT_W-1:0] filtered;
    logic [psc_pkg::COUNT_W-1:0] average;
    logic                        full;
  } reading_t;

  typedef enum logic [1:0] {STEP_SAMPLE, STEP_KNOWN, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    reading_t    known;
  } step_t;

  localparam step_t DIRECTED_STEPS [36] = '{
    '{STEP_KNOWN,  '0, 32'd4095, '{16'd50000, 12'd4095, 12'd4095, 1'b0}},
    '{STEP_SAMPLE, '0, 32'd0,    '0},
    '{STEP_SAMPLE, '0, 32'd2048, '0},
    '{STEP_SAMPLE, '0, 32'd2047, '0},
    '{STEP_WRITE,  psc_pkg::REG_FILTER_MODE, 32'(MODE_UNUSED), '0},
    '{STEP_SAMPLE, '0, 32'hAAA,  '0},
    '{STEP_SAMPLE, '0, 32'h555,  '0},
    '{STEP_WRITE,  psc_pkg::REG_FILTER_MODE, 32'(psc_pkg::MODE_MEDIAN), '0},
    '{STEP_SAMPLE, '0, 32'd100,  '0},
    '{STEP_SAMPLE, '0, 32'd4000, '0},
    '{STEP_SAMPLE, '0, 32'd50,   '0},
    '{STEP_SAMPLE, '0, 32'd3000, '0},
    '{STEP_WRITE,  psc_pkg::REG_EMA_ALPHA, 32'(psc_pkg::ALPHA_ONE), '0},
    '{STEP_WRITE,  psc_pkg::REG_FILTER_MODE, 32'(psc_pkg::MODE_EMA), '0},
    '{STEP_SAMPLE, '0, 32'd1000, '0},
    '{STEP_SAMPLE, '0, 32'd2000, '0},
    '{STEP_WRITE,  psc_pkg::REG_EMA_ALPHA, 32'd0, '0},
    '{STEP_SAMPLE, '0, 32'd4095, '0},
    '{STEP_WRITE,  psc_pkg::REG_EMA_ALPHA, 32'd511, '0},
    '{STEP_SAMPLE, '0, 32'd7,    '0},
    '{STEP_WRITE,  psc_pkg::REG_FILTER_MODE, 32'(psc_pkg::MODE_NONE), '0},
    '{STEP_WRITE,  psc_pkg::REG_CLAMP_LOW, 32'd3000, '0},
    '{STEP_WRITE,  psc_pkg::REG_CLAMP_HIGH, 32'd1000, '0},
    '{STEP_SAMPLE, '0, 32'd0,    '0},
    '{STEP_SAMPLE, '0, 32'd4095, '0},
    '{STEP_WRITE,  psc_pkg::REG_CLAMP_HIGH, 32'd0, '0},
    '{STEP_SAMPLE, '0, 32'd1234, '0},
    '{STEP_WRITE,  psc_pkg::REG_CLAMP_LOW, 32'd0, '0},
    '{STEP_WRITE,  psc_pkg::REG_CLAMP_HIGH, 32'd4095, '0},
    '{STEP_WRITE,  psc_pkg::REG_SPAN, 32'd131071, '0},
    '{STEP_WRITE,  psc_pkg::REG_OFFSET, 32'd65535, '0},
    '{STEP_WRITE,  psc_pkg::REG_MAX, 32'd65535, '0},
    '{STEP_SAMPLE, '0, 32'd4095, '0},
    '{STEP_SAMPLE, '0, 32'd0,    '0},
    '{STEP_WRITE,  psc_pkg::REG_SPAN, 32'd0, '0},
    '{STEP_SAMPLE, '0, 32'd2000, '0}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [11:0]                  in_adc_sample;
  logic                         out_valid;
  logic                         out_stall;
  logic [15:0]                  out_pressure_tenths;
  logic [11:0]                  out_filtered_count;
  logic [11:0]                  out_average_count;
  logic                         out_window_full;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [psc_pkg::ADDR_W-1:0]   paddr;
  logic [psc_pkg::DATA_W-1:0]   pwdata;
  logic [psc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  pressure_sample_conditioner u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_adc_sample       (in_adc_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pressure_tenths (out_pressure_tenths),
    .out_filtered_count  (out_filtered_count),
    .out_average_count   (out_average_count),
    .out_window_full     (out_window_full),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  logic [1:0]                  mode_q  = psc_pkg::MODE_NONE;
  logic [psc_pkg::ALPHA_W-1:0] alpha_q = psc_pkg::RST_ALPHA;
  logic [psc_pkg::COUNT_W-1:0] lo_q    = '0;
  logic [psc_pkg::COUNT_W-1:0] hi_q    = psc_pkg::RST_HIGH;
  logic [psc_pkg::SPAN_W-1:0]  span_q  = psc_pkg::RST_SPAN;
  logic [psc_pkg::PRESS_W-1:0] off_q   = psc_pkg::RST_OFFSET;
  logic [psc_pkg::PRESS_W-1:0] max_q   = psc_pkg::RST_MAX;

  logic [psc_pkg::COUNT_W-1:0] win_store [psc_pkg::WINDOW_DEPTH];
  int unsigned                 win_sum = 0;
  int unsigned                 wr_pos  = 0;
  int unsigned                 fill_n  = 0;
  logic [psc_pkg::EMA_W-1:0]   ema_acc = '0;
  logic [psc_pkg::COUNT_W-1:0] med_prev1 = '0;
  logic [psc_pkg::COUNT_W-1:0] med_prev2 = '0;
  bit                          med_primed = 1'b0;

  reading_t pending_readings [$];
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       signal_level = 2048;
  bit       holding_off = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic reading_t predict_reading(input logic [psc_pkg::COUNT_W-1:0] raw);
    logic [psc_pkg::COUNT_W-1:0] x, f, a, b, cnt;
    longint unsigned             weight, acc, divisor, scaled, level;
    reading_t                    r;
    x = raw & psc_pkg::ADC_MASK;
    f = x;
    if (mode_q == psc_pkg::MODE_MEDIAN) begin
      a = med_prev1;
      b = med_prev2;
      if (!med_primed) begin
        a = x;
        b = x;
        med_primed = 1'b1;
      end
      if ((x >= a && x <= b) || (x >= b && x <= a)) f = x;
      else if ((a >= x && a <= b) || (a >= b && a <= x)) f = a;
      else f = b;
      med_prev2 = a;
      med_prev1 = x;
    end else if (mode_q == psc_pkg::MODE_EMA) begin
      weight = (alpha_q > psc_pkg::ALPHA_ONE) ? longint'(psc_pkg::ALPHA_ONE) :
               longint'(alpha_q);
      if (ema_acc == '0) ema_acc = {x, {psc_pkg::EMA_FRAC{1'b0}}};
      acc = weight * (longint'(x) << psc_pkg::EMA_FRAC)
          + (longint'(psc_pkg::ALPHA_ONE) - weight) * longint'(ema_acc);
      ema_acc = psc_pkg::EMA_W'(acc >> psc_pkg::EMA_FRAC);
      f = ema_acc[psc_pkg::EMA_W-1:psc_pkg::EMA_FRAC];
    end
    if (fill_n >= psc_pkg::WINDOW_DEPTH) win_sum -= 32'(win_store[wr_pos]);
    else fill_n++;
    win_store[wr_pos] = f;
    win_sum += 32'(f);
    wr_pos = (wr_pos + 1) % psc_pkg::WINDOW_DEPTH;
    r.average = psc_pkg::COUNT_W'(win_sum / fill_n);
    cnt = r.average;
    if (cnt < lo_q) cnt = lo_q;
    if (cnt > hi_q) cnt = hi_q;
    divisor = (hi_q == '0) ? 64'd1 : longint'(hi_q);
    scaled = longint'(cnt) * longint'(span_q) / divisor;
    level = (scaled > longint'(off_q)) ? scaled - longint'(off_q) : 64'd0;
    if (level > longint'(max_q)) level = longint'(max_q);
    r.pressure = psc_pkg::PRESS_W'(level);
    r.filtered = f;
    r.full = (fill_n >= psc_pkg::WINDOW_DEPTH);
    return r;
  endfunction

  function automatic logic [11:0] next_sample();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'hFFF;
      2, 3: return 12'($urandom_range(4095));
      default: begin
        signal_level += int'($urandom_range(400)) - 200;
        if (signal_level < 0) signal_level = 0;
        if (signal_level > 4095) signal_level = 4095;
        return 12'(signal_level);
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      psc_pkg::REG_FILTER_MODE: mode_q  = v[1:0];
      psc_pkg::REG_EMA_ALPHA:   alpha_q = v[psc_pkg::ALPHA_W-1:0];
      psc_pkg::REG_CLAMP_LOW:   lo_q    = v[psc_pkg::COUNT_W-1:0];
      psc_pkg::REG_CLAMP_HIGH:  hi_q    = v[psc_pkg::COUNT_W-1:0];
      psc_pkg::REG_SPAN:        span_q  = v[psc_pkg::SPAN_W-1:0];
      psc_pkg::REG_OFFSET:      off_q   = v[psc_pkg::PRESS_W-1:0];
      psc_pkg::REG_MAX:         max_q   = v[psc_pkg::PRESS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [11:0] s, output reading_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
    want = predict_reading(s);
  endtask

  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic hold_results(input int cycles);
    holding_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    holding_off <= 1'b0;
  endtask

  task automatic shuffle_settings();
    write_register(psc_pkg::REG_FILTER_MODE, $urandom_range(3));
    case ($urandom_range(7))
      0: write_register(psc_pkg::REG_EMA_ALPHA, 0);
      1: write_register(psc_pkg::REG_EMA_ALPHA, 32'(psc_pkg::ALPHA_ONE));
      2: write_register(psc_pkg::REG_EMA_ALPHA, 511);
      default: write_register(psc_pkg::REG_EMA_ALPHA, $urandom_range(511));
    endcase
    case ($urandom_range(7))
      0: write_register(psc_pkg::REG_CLAMP_LOW, 0);
      1: write_register(psc_pkg::REG_CLAMP_LOW, 4095);
      default: write_register(psc_pkg::REG_CLAMP_LOW, $urandom_range(1500));
    endcase
    case ($urandom_range(7))
      0: write_register(psc_pkg::REG_CLAMP_HIGH, 0);
      1: write_register(psc_pkg::REG_CLAMP_HIGH, 1);
      2: write_register(psc_pkg::REG_CLAMP_HIGH, 4095);
      default: write_register(psc_pkg::REG_CLAMP_HIGH, $urandom_range(2000, 4095));
    endcase
    case ($urandom_range(7))
      0: write_register(psc_pkg::REG_SPAN, 0);
      1: write_register(psc_pkg::REG_SPAN, 131071);
      default: write_register(psc_pkg::REG_SPAN, $urandom_range(131071));
    endcase
    case ($urandom_range(7))
      0: write_register(psc_pkg::REG_OFFSET, 0);
      1: write_register(psc_pkg::REG_OFFSET, 65535);
      default: write_register(psc_pkg::REG_OFFSET, $urandom_range(30000));
    endcase
    case ($urandom_range(7))
      0: write_register(psc_pkg::REG_MAX, 0);
      1: write_register(psc_pkg::REG_MAX, 65535);
      default: write_register(psc_pkg::REG_MAX, $urandom_range(65535));
    endcase
  endtask

  always @(posedge clk) begin
    out_stall <= holding_off || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("unexpected beat, pressure", longint'(out_pressure_tenths), 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_pressure_tenths !== want.pressure)
          flag_mismatch("pressure_tenths", longint'(out_pressure_tenths),
                        longint'(want.pressure));
        if (out_filtered_count !== want.filtered)
          flag_mismatch("filtered_count", longint'(out_filtered_count),
                        longint'(want.filtered));
        if (out_average_count !== want.average)
          flag_mismatch("average_count", longint'(out_average_count),
                        longint'(want.average));
        if (out_window_full !== want.full)
          flag_mismatch("window_full", longint'(out_window_full), longint'(want.full));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reading_t want;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_adc_sample <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == STEP_WRITE) begin
        wait_drained();
        write_register(DIRECTED_STEPS[i].reg_idx, DIRECTED_STEPS[i].value);
      end else begin
        send_sample(DIRECTED_STEPS[i].value[11:0], want);
        if (DIRECTED_STEPS[i].kind == STEP_KNOWN)
          pending_readings.push_back(DIRECTED_STEPS[i].known);
        else
          pending_readings.push_back(want);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      shuffle_settings();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      // back up the block with a long stall on the result side
      if (phase == 4) fork hold_results(400); join_none
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        send_sample(next_sample(), want);
        pending_readings.push_back(want);
        if (phase == 6 && k == BEATS_PER_PHASE / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0)
      flag_mismatch("beats never delivered", longint'(pending_readings.size()), 0);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/psc_pkg.sv
rtl/psc_ram.sv
rtl/pressure_sample_conditioner.sv
tb/tb.sv
